### hw/rtl/scfs_pkg.sv
// scfs_pkg: shared types and constants for the square channel frame sequencer
// no dependencies; used by the interfaces, the channel module, the top and the checker
`default_nettype none

package scfs_pkg;

    // frame sequencer and register bank sizing
    localparam int SEQUENCER_PERIOD = 8192;
    localparam int BANK_DEPTH       = 48;
    localparam int ACC_W            = $clog2(SEQUENCER_PERIOD + 256);
    localparam int BANK_AW          = $clog2(BANK_DEPTH);

    // item commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // register offsets from the base of the sound register area
    localparam logic [5:0] OFS_SQ1_LEN  = 6'd1;
    localparam logic [5:0] OFS_SQ1_ENV  = 6'd2;
    localparam logic [5:0] OFS_SQ1_LO   = 6'd3;
    localparam logic [5:0] OFS_SQ1_TRIG = 6'd4;
    localparam logic [5:0] OFS_SQ2_LEN  = 6'd6;
    localparam logic [5:0] OFS_SQ2_ENV  = 6'd7;
    localparam logic [5:0] OFS_SQ2_LO   = 6'd8;
    localparam logic [5:0] OFS_SQ2_TRIG = 6'd9;
    localparam logic [5:0] OFS_STATUS   = 6'd22;

    // full length counter
    localparam logic [6:0] LEN_FULL = 7'd64;

    // envelope step at which the volume envelopes are clocked
    localparam logic [2:0] STEP_ENV = 3'd7;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] reg_offset;
        logic [7:0] write_byte;
        logic [7:0] tick_cycles;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic        first_on;
        logic        second_on;
        logic [3:0]  first_volume;
        logic [3:0]  second_volume;
        logic [10:0] first_period;
        logic [10:0] second_period;
    } t_out_item;

    // per channel control for one accepted transaction
    typedef struct packed {
        logic       len_load;
        logic       trig;
        logic       len_clk;
        logic       env_clk;
        logic [7:0] wr_byte;
        logic [7:0] env_byte;
        logic [7:0] lo_byte;
    } t_ch_ctl;

endpackage

`default_nettype wire

### hw/rtl/scfs_if.sv
// scfs_if: valid/ready channel interfaces for input items and result items
// depends on scfs_pkg for the payload structs
`default_nettype none

interface scfs_in_if
    import scfs_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface scfs_out_if
    import scfs_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/scfs_channel.sv
// scfs_channel: length counter, envelope and trigger state of one square channel
// depends on scfs_pkg for t_ch_ctl and constants
`default_nettype none

module scfs_channel
    import scfs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_ch_ctl     i_ctl,
    output logic             o_on,
    output logic [3:0]       o_volume,
    output logic [10:0]      o_period
);

    logic        r_on, n_on;
    logic        r_len_en, n_len_en;
    logic [6:0]  r_len_cnt, n_len_cnt;
    logic [10:0] r_period, n_period;
    logic [3:0]  r_vol, n_vol;
    logic [2:0]  r_env_cnt, n_env_cnt;

    logic [6:0]  len_dec;
    logic [2:0]  env_per;

    assign len_dec = r_len_cnt - 7'd1;
    assign env_per = i_ctl.env_byte[2:0];

    // next state for the one event this transaction carries
    always_comb begin
        n_on      = r_on;
        n_len_en  = r_len_en;
        n_len_cnt = r_len_cnt;
        n_period  = r_period;
        n_vol     = r_vol;
        n_env_cnt = r_env_cnt;

        if (i_ctl.len_load) begin
            n_len_cnt = LEN_FULL - {1'b0, i_ctl.wr_byte[5:0]};
        end
        if (i_ctl.trig) begin
            n_on      = i_ctl.wr_byte[7];
            n_len_en  = i_ctl.wr_byte[6];
            n_period  = {i_ctl.wr_byte[2:0], i_ctl.lo_byte};
            n_env_cnt = env_per;
            n_vol     = i_ctl.env_byte[7:4];
            if (i_ctl.wr_byte[7] && (r_len_cnt == 7'd0)) begin
                n_len_cnt = LEN_FULL;
            end
        end
        // length clock turns the channel off when the count runs out
        if (i_ctl.len_clk && r_on && r_len_en && (r_len_cnt != 7'd0)) begin
            n_len_cnt = len_dec;
            if (len_dec == 7'd0) begin
                n_on = 1'b0;
            end
        end
        // envelope clock, volume saturates at both ends
        if (i_ctl.env_clk) begin
            if (r_env_cnt != 3'd0) begin
                n_env_cnt = r_env_cnt - 3'd1;
            end else if (env_per != 3'd0) begin
                n_env_cnt = env_per;
                if (i_ctl.env_byte[3]) begin
                    if (r_vol != 4'hF) begin
                        n_vol = r_vol + 4'd1;
                    end
                end else begin
                    if (r_vol != 4'h0) begin
                        n_vol = r_vol - 4'd1;
                    end
                end
            end
        end
    end

    // channel state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on      <= 1'b0;
            r_len_en  <= 1'b0;
            r_len_cnt <= '0;
            r_period  <= '0;
            r_vol     <= '0;
            r_env_cnt <= '0;
        end else begin
            r_on      <= n_on;
            r_len_en  <= n_len_en;
            r_len_cnt <= n_len_cnt;
            r_period  <= n_period;
            r_vol     <= n_vol;
            r_env_cnt <= n_env_cnt;
        end
    end

    assign o_on     = r_on;
    assign o_volume = r_vol;
    assign o_period = r_period;

endmodule

`default_nettype wire

### hw/rtl/square_channel_frame_sequencer_top.sv
// square_channel_frame_sequencer_top: frame sequencer, register bank and two square channels
// depends on scfs_pkg, scfs_if and scfs_channel
//
// Each accepted transaction is a cycle tick, a register write or read, or a no-op, and
// produces exactly one result in the next cycle, holding the read data and both channels'
// enable, volume and period after the transaction. One transaction is accepted every
// clock while the result side takes results; i_in.ready follows o_out.ready whenever a
// result is pending. The 48 byte register bank is a single port memory with a registered
// read, so read data appears with the result; entries never written read as zero through
// per entry valid bits, so no clearing pass is needed after reset.
`default_nettype none

module square_channel_frame_sequencer_top
    import scfs_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    scfs_in_if.sink     i_in,
    scfs_out_if.source  o_out
);

    logic                   acc_in;
    logic                   r_out_vld;

    logic [ACC_W-1:0]       r_acc;
    logic [ACC_W-1:0]       acc_sum;
    logic [2:0]             r_step;
    logic [2:0]             step_inc;
    logic                   seq_fire;

    logic [7:0]             r_mem [BANK_DEPTH];
    logic [BANK_DEPTH-1:0]  r_bank_vld;
    logic [7:0]             r_mem_q;
    logic                   r_rd_mem;
    logic [7:0]             r_rd_fix;
    logic [7:0]             r_env1, r_lo1, r_env2, r_lo2;
    logic                   r_pwr;

    logic                   is_tick, is_wr, is_rd;
    logic [5:0]             ofs;
    logic                   in_bank;
    logic                   bank_wr;
    logic                   len_clk, env_clk;
    t_ch_ctl                ctl1, ctl2;
    logic                   on1, on2;
    logic [3:0]             vol1, vol2;
    logic [10:0]            per1, per2;

    // handshake: output register parts the two sides
    assign i_in.ready = !r_out_vld || o_out.ready;
    assign acc_in     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (acc_in) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // decode of the incoming transaction
    assign ofs     = i_in.data.reg_offset;
    assign is_tick = acc_in && (i_in.data.cmd == CMD_TICK);
    assign is_wr   = acc_in && (i_in.data.cmd == CMD_WRITE);
    assign is_rd   = acc_in && (i_in.data.cmd == CMD_READ);
    assign in_bank = ({1'b0, ofs} < 7'(BANK_DEPTH));
    assign bank_wr = is_wr && in_bank && (ofs != OFS_SQ1_LEN) && (ofs != OFS_SQ1_TRIG)
                     && (ofs != OFS_SQ2_LEN) && (ofs != OFS_SQ2_TRIG);

    // frame sequencer accumulator and step counter
    assign acc_sum  = r_acc + ACC_W'(i_in.data.tick_cycles);
    assign seq_fire = is_tick && (acc_sum >= ACC_W'(SEQUENCER_PERIOD));
    assign step_inc = r_step + 3'd1;
    assign len_clk  = seq_fire && !step_inc[0];
    assign env_clk  = seq_fire && (step_inc == STEP_ENV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_step <= '0;
        end else if (is_tick) begin
            if (seq_fire) begin
                r_acc  <= acc_sum - ACC_W'(SEQUENCER_PERIOD);
                r_step <= step_inc;
            end else begin
                r_acc  <= acc_sum;
            end
        end
    end

    // copies of the bank bytes that the channel logic uses every transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env1 <= '0;
            r_lo1  <= '0;
            r_env2 <= '0;
            r_lo2  <= '0;
            r_pwr  <= 1'b0;
        end else if (bank_wr) begin
            if (ofs == OFS_SQ1_ENV) begin
                r_env1 <= i_in.data.write_byte;
            end
            if (ofs == OFS_SQ1_LO) begin
                r_lo1 <= i_in.data.write_byte;
            end
            if (ofs == OFS_SQ2_ENV) begin
                r_env2 <= i_in.data.write_byte;
            end
            if (ofs == OFS_SQ2_LO) begin
                r_lo2 <= i_in.data.write_byte;
            end
            if (ofs == OFS_STATUS) begin
                r_pwr <= i_in.data.write_byte[7];
            end
        end
    end

    // register bank memory, one write or one registered read per transaction
    always_ff @(posedge i_clk) begin
        if (bank_wr) begin
            r_mem[ofs[BANK_AW-1:0]] <= i_in.data.write_byte;
        end
        if (is_rd && in_bank) begin
            r_mem_q <= r_mem[ofs[BANK_AW-1:0]];
        end
    end

    // valid bits stand in for clearing the bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_vld <= '0;
        end else if (bank_wr) begin
            r_bank_vld[ofs[BANK_AW-1:0]] <= 1'b1;
        end
    end

    // read data select, status byte built from current channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_mem <= 1'b0;
            r_rd_fix <= '0;
        end else if (acc_in) begin
            r_rd_mem <= is_rd && in_bank && (ofs != OFS_STATUS)
                        && r_bank_vld[ofs[BANK_AW-1:0]];
            if (is_rd && (ofs == OFS_STATUS)) begin
                r_rd_fix <= {r_pwr, 5'b0, on2, on1};
            end else begin
                r_rd_fix <= '0;
            end
        end
    end

    // channel controls
    always_comb begin
        ctl1.len_load = is_wr && (ofs == OFS_SQ1_LEN);
        ctl1.trig     = is_wr && (ofs == OFS_SQ1_TRIG);
        ctl1.len_clk  = len_clk;
        ctl1.env_clk  = env_clk;
        ctl1.wr_byte  = i_in.data.write_byte;
        ctl1.env_byte = r_env1;
        ctl1.lo_byte  = r_lo1;

        ctl2.len_load = is_wr && (ofs == OFS_SQ2_LEN);
        ctl2.trig     = is_wr && (ofs == OFS_SQ2_TRIG);
        ctl2.len_clk  = len_clk;
        ctl2.env_clk  = env_clk;
        ctl2.wr_byte  = i_in.data.write_byte;
        ctl2.env_byte = r_env2;
        ctl2.lo_byte  = r_lo2;
    end

    scfs_channel u_ch1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl1),
        .o_on     (on1),
        .o_volume (vol1),
        .o_period (per1)
    );

    scfs_channel u_ch2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl2),
        .o_on     (on2),
        .o_volume (vol2),
        .o_period (per2)
    );

    // result transaction; channel state only changes on acceptance, so it holds while stalled
    assign o_out.valid              = r_out_vld;
    assign o_out.data.read_byte     = r_rd_mem ? r_mem_q : r_rd_fix;
    assign o_out.data.first_on      = on1;
    assign o_out.data.second_on     = on2;
    assign o_out.data.first_volume  = vol1;
    assign o_out.data.second_volume = vol2;
    assign o_out.data.first_period  = per1;
    assign o_out.data.second_period = per2;

endmodule

`default_nettype wire

### hw/rtl/scfs_checker.sv
// scfs_checker: port level assertions for the square channel frame sequencer top
// depends on scfs_pkg; bound to square_channel_frame_sequencer_top below
`default_nettype none

module scfs_checker
    import scfs_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      i_in_ready,
    input wire t_in_item  i_in_data,
    input wire logic      i_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item i_out_data
);

    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    // a pending result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before it was taken");

    // every accepted transaction yields a result on the next clock
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> i_out_valid)
        else $error("accepted transaction gave no result");

    // only reads return data
    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_data.cmd != CMD_READ) |=> (i_out_data.read_byte == 8'd0))
        else $error("read data on a non-read transaction");

    // channel one only turns on through its trigger register
    a_ch1_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_data.first_on) |-> $past(in_acc && (i_in_data.cmd == CMD_WRITE)
                                             && (i_in_data.reg_offset == OFS_SQ1_TRIG)))
        else $error("channel one enabled without a trigger write");

endmodule

bind square_channel_frame_sequencer_top scfs_checker u_scfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_data   (i_in.data),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire

### tb/square_channel_frame_sequencer_top_test.sv
// square_channel_frame_sequencer_top_test: self-checking bench for the square channel sequencer
// depends on scfs_pkg, scfs_if and the rtl of square_channel_frame_sequencer_top
// predicts each transaction's channel snapshot and compares it with the result stream
`timescale 1ns / 100ps

module square_channel_frame_sequencer_top_test;
    import scfs_pkg::*;

    localparam logic [7:0] STATUS_POWER = 8'h80;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    scfs_in_if  in_bus ();
    scfs_out_if out_bus ();

    square_channel_frame_sequencer_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow copy of the sound unit state
    logic [13:0] cyc_acc;
    logic [2:0]  seq_step;
    logic [1:0]  ch_on;
    logic [1:0]  len_en;
    logic [6:0]  len_cnt [2];
    logic [10:0] ch_period [2];
    logic [3:0]  ch_vol [2];
    logic [2:0]  env_cnt [2];
    logic [7:0]  reg_bank [BANK_DEPTH];

    t_out_item expected_snapshots [$];

    bit steady_phase = 1'b0;
    int fail_count = 0;
    int items_accepted = 0;
    int ticks_seen = 0;
    int writes_seen = 0;
    int reads_seen = 0;
    int step_count = 0;
    int expiry_count = 0;
    int env_step_count = 0;

    function automatic logic [7:0] bank_byte(input logic [5:0] ofs);
        return ({1'b0, ofs} < 7'(BANK_DEPTH)) ? reg_bank[ofs] : 8'h00;
    endfunction

    // length counters, clocked on even sequencer steps
    function automatic void clock_length();
        for (int c = 0; c < 2; c++) begin
            if (ch_on[c] && len_en[c] && len_cnt[c] != 7'd0) begin
                len_cnt[c] = len_cnt[c] - 7'd1;
                if (len_cnt[c] == 7'd0) begin
                    ch_on[c] = 1'b0;
                    expiry_count++;
                end
            end
        end
    endfunction

    // volume envelopes, clocked on the last sequencer step
    function automatic void clock_envelope();
        logic [7:0] env;
        for (int c = 0; c < 2; c++) begin
            env = bank_byte(c ? OFS_SQ2_ENV : OFS_SQ1_ENV);
            if (env_cnt[c] != 3'd0) begin
                env_cnt[c] = env_cnt[c] - 3'd1;
            end else if (env[2:0] != 3'd0) begin
                env_cnt[c] = env[2:0];
                if (env[3]) begin
                    if (ch_vol[c] != 4'd15) begin
                        ch_vol[c] = ch_vol[c] + 4'd1;
                        env_step_count++;
                    end
                end else if (ch_vol[c] != 4'd0) begin
                    ch_vol[c] = ch_vol[c] - 4'd1;
                    env_step_count++;
                end
            end
        end
    endfunction

    function automatic void trigger_channel(input int c, input logic [7:0] v);
        logic [7:0] env;
        env = bank_byte(c ? OFS_SQ2_ENV : OFS_SQ1_ENV);
        ch_on[c] = v[7];
        len_en[c] = v[6];
        ch_period[c] = {v[2:0], bank_byte(c ? OFS_SQ2_LO : OFS_SQ1_LO)};
        if (ch_on[c] && len_cnt[c] == 7'd0)
            len_cnt[c] = LEN_FULL;
        env_cnt[c] = env[2:0];
        ch_vol[c] = env[7:4];
    endfunction

    // apply one transaction to the shadow state and return the channel snapshot
    function automatic t_out_item channel_snapshot(input t_in_item it);
        t_out_item snap;
        logic [7:0] rd;
        rd = 8'h00;
        case (it.cmd)
            CMD_TICK: begin
                ticks_seen++;
                cyc_acc = cyc_acc + 14'(it.tick_cycles);
                if (cyc_acc >= 14'(SEQUENCER_PERIOD)) begin
                    cyc_acc = cyc_acc - 14'(SEQUENCER_PERIOD);
                    seq_step = seq_step + 3'd1;
                    step_count++;
                    if (!seq_step[0])
                        clock_length();
                    else if (seq_step == STEP_ENV)
                        clock_envelope();
                end
            end
            CMD_WRITE: begin
                writes_seen++;
                case (it.reg_offset)
                    OFS_SQ1_LEN:  len_cnt[0] = LEN_FULL - {1'b0, it.write_byte[5:0]};
                    OFS_SQ1_TRIG: trigger_channel(0, it.write_byte);
                    OFS_SQ2_LEN:  len_cnt[1] = LEN_FULL - {1'b0, it.write_byte[5:0]};
                    OFS_SQ2_TRIG: trigger_channel(1, it.write_byte);
                    default: begin
                        if ({1'b0, it.reg_offset} < 7'(BANK_DEPTH))
                            reg_bank[it.reg_offset] = it.write_byte;
                    end
                endcase
            end
            CMD_READ: begin
                reads_seen++;
                if (it.reg_offset == OFS_STATUS) begin
                    rd = bank_byte(OFS_STATUS) & STATUS_POWER;
                    rd[0] = ch_on[0];
                    rd[1] = ch_on[1];
                end else begin
                    rd = bank_byte(it.reg_offset);
                end
            end
            default: ;
        endcase
        snap.read_byte = rd;
        snap.first_on = ch_on[0];
        snap.second_on = ch_on[1];
        snap.first_volume = ch_vol[0];
        snap.second_volume = ch_vol[1];
        snap.first_period = ch_period[0];
        snap.second_period = ch_period[1];
        return snap;
    endfunction

    // drive one transaction and wait for its acceptance, valid stays high afterwards
    task automatic send_item(input logic [1:0] cmd, input logic [5:0] ofs,
                             input logic [7:0] wb, input logic [7:0] cyc);
        t_in_item it;
        it.cmd = cmd;
        it.reg_offset = ofs;
        it.write_byte = wb;
        it.tick_cycles = cyc;
        while (!steady_phase && $urandom_range(99) < 34) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.data <= it;
        do @(posedge i_clk); while (!in_bus.ready);
        expected_snapshots.push_back(channel_snapshot(it));
        items_accepted++;
    endtask

    task automatic write_reg(input logic [5:0] ofs, input logic [7:0] b);
        send_item(CMD_WRITE, ofs, b, 8'($urandom_range(255)));
    endtask

    task automatic read_reg(input logic [5:0] ofs);
        send_item(CMD_READ, ofs, 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic tick(input logic [7:0] cyc);
        send_item(CMD_TICK, 6'($urandom_range(63)), 8'($urandom_range(255)), cyc);
    endtask

    // result side stalls at random except during the steady phase
    initial begin
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_bus.ready <= steady_phase || ($urandom_range(99) >= 34);
        end
    end

    task automatic check_field(input string name, input logic [10:0] exp_v,
                               input logic [10:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item exp_s;
        t_out_item act_s;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            act_s = out_bus.data;
            if (expected_snapshots.size() == 0) begin
                $error("result transaction with no prediction pending");
                fail_count++;
            end else begin
                exp_s = expected_snapshots.pop_front();
                check_field("read_byte", 11'(exp_s.read_byte), 11'(act_s.read_byte));
                check_field("first_on", 11'(exp_s.first_on), 11'(act_s.first_on));
                check_field("second_on", 11'(exp_s.second_on), 11'(act_s.second_on));
                check_field("first_volume", 11'(exp_s.first_volume),
                            11'(act_s.first_volume));
                check_field("second_volume", 11'(exp_s.second_volume),
                            11'(act_s.second_volume));
                check_field("first_period", exp_s.first_period, act_s.first_period);
                check_field("second_period", exp_s.second_period, act_s.second_period);
            end
        end
    end

    // state straight after reset, tick extremes
    task automatic test_reset_state();
        read_reg(OFS_STATUS);
        read_reg(6'd47);
        tick(8'd0);
        tick(8'd255);
    endtask

    // byte bank, out of range offsets and the unused command
    task automatic test_register_bank();
        write_reg(6'd0, 8'hFF);
        read_reg(6'd0);
        write_reg(OFS_STATUS, 8'hFF);
        read_reg(OFS_STATUS);
        write_reg(6'd48, 8'hAA);
        read_reg(6'd48);
        write_reg(6'd63, 8'h55);
        read_reg(6'd63);
        send_item(CMD_UNUSED, 6'd63, 8'hFF, 8'hFF);
    endtask

    // trigger, length load and status with both channels
    task automatic test_channel_trigger();
        write_reg(OFS_SQ1_ENV, 8'hF8);
        write_reg(OFS_SQ1_LO, 8'hFF);
        write_reg(OFS_SQ1_LEN, 8'h3F);
        write_reg(OFS_SQ1_TRIG, 8'hC7);
        write_reg(OFS_SQ2_ENV, 8'h07);
        write_reg(OFS_SQ2_LEN, 8'h00);
        write_reg(OFS_SQ2_TRIG, 8'h80);
        read_reg(OFS_STATUS);
        read_reg(OFS_SQ1_TRIG);
        read_reg(OFS_SQ2_LEN);
        write_reg(OFS_SQ2_TRIG, 8'h00);
    endtask

    // mostly tick bursts and channel setups with random content, some noise
    task automatic test_random_traffic(input int count);
        int start_items;
        int scenario;
        int burst;
        int c;
        logic [7:0] b;
        start_items = items_accepted;
        while (items_accepted - start_items < count) begin
            steady_phase = (items_accepted - start_items >= count / 3) &&
                           (items_accepted - start_items < count / 3 + 100);
            scenario = $urandom_range(99);
            c = $urandom_range(1);
            if (scenario < 55) begin
                burst = $urandom_range(12, 1);
                repeat (burst) begin
                    if ($urandom_range(99) < 85)
                        tick(8'($urandom_range(255, 200)));
                    else
                        tick(8'($urandom_range(255)));
                end
            end else if (scenario < 75) begin
                b = 8'($urandom_range(255));
                if (b[2:0] == 3'd0 && $urandom_range(1))
                    b[2:0] = 3'd1;
                write_reg(c ? OFS_SQ2_ENV : OFS_SQ1_ENV, b);
                write_reg(c ? OFS_SQ2_LO : OFS_SQ1_LO, 8'($urandom_range(255)));
                b = 8'($urandom_range(255));
                if ($urandom_range(1))
                    b[5:0] = 6'($urandom_range(63, 56));
                write_reg(c ? OFS_SQ2_LEN : OFS_SQ1_LEN, b);
                b = 8'($urandom_range(255));
                b[7] = ($urandom_range(99) < 80);
                b[6] = ($urandom_range(99) < 70);
                write_reg(c ? OFS_SQ2_TRIG : OFS_SQ1_TRIG, b);
                // a rewritten envelope after trigger lets the volume step at once
                if ($urandom_range(1))
                    write_reg(c ? OFS_SQ2_ENV : OFS_SQ1_ENV, 8'($urandom_range(255)));
            end else if (scenario < 87) begin
                case ($urandom_range(2))
                    0: read_reg(OFS_STATUS);
                    1: read_reg(c ? OFS_SQ2_ENV : OFS_SQ1_LO);
                    default: read_reg(6'($urandom_range(63)));
                endcase
            end else if (scenario < 95) begin
                if ($urandom_range(1))
                    write_reg(OFS_STATUS, 8'($urandom_range(255)));
                else
                    write_reg(6'($urandom_range(BANK_DEPTH - 1)), 8'($urandom_range(255)));
            end else begin
                send_item(2'($urandom_range(3)), 6'($urandom_range(63)),
                          8'($urandom_range(255)), 8'($urandom_range(255)));
            end
        end
        steady_phase = 1'b0;
    endtask

    // main sequence
    initial begin
        int drain;
        in_bus.valid <= 1'b0;
        in_bus.data <= '0;
        cyc_acc = '0;
        seq_step = '0;
        ch_on = '0;
        len_en = '0;
        for (int c = 0; c < 2; c++) begin
            len_cnt[c] = '0;
            ch_period[c] = '0;
            ch_vol[c] = '0;
            env_cnt[c] = '0;
        end
        for (int i = 0; i < BANK_DEPTH; i++)
            reg_bank[i] = 8'h00;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_register_bank();
        test_channel_trigger();
        test_random_traffic(400);

        in_bus.valid <= 1'b0;
        drain = 0;
        while (expected_snapshots.size() != 0 && drain < 5000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (4) @(posedge i_clk);
        if (expected_snapshots.size() != 0) begin
            $error("%0d predicted results never arrived", expected_snapshots.size());
            fail_count++;
        end

        $display("ran %0d transactions: %0d ticks, %0d writes, %0d reads",
                 items_accepted, ticks_seen, writes_seen, reads_seen);
        $display("sequencer advanced %0d steps, %0d length expiries, %0d volume steps",
                 step_count, expiry_count, env_step_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
